>>> rtl/core/i2cmts_pkg.sv
// Shared types and constants for the I2C master transfer sequencer.
// No dependencies; used by every module of the block.
package i2cmts_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic [1:0] OP_START_RD = 2'd0;
    localparam logic [1:0] OP_START_WR = 2'd1;
    localparam logic [1:0] OP_STATUS   = 2'd2;

    localparam logic [7:0] ST_START    = 8'h08;
    localparam logic [7:0] ST_RESTART  = 8'h10;
    localparam logic [7:0] ST_AW_ACK   = 8'h18;
    localparam logic [7:0] ST_AW_NACK  = 8'h20;
    localparam logic [7:0] ST_TX_ACK   = 8'h28;
    localparam logic [7:0] ST_TX_NACK  = 8'h30;
    localparam logic [7:0] ST_ARB_LOST = 8'h38;
    localparam logic [7:0] ST_AR_ACK   = 8'h40;
    localparam logic [7:0] ST_AR_NACK  = 8'h48;
    localparam logic [7:0] ST_RX_ACK   = 8'h50;
    localparam logic [7:0] ST_RX_NACK  = 8'h58;

    localparam logic [1:0] ACK_NONE = 2'd0;
    localparam logic [1:0] ACK_ACK  = 2'd1;
    localparam logic [1:0] ACK_NACK = 2'd2;

    localparam logic REG_SLAVE_ADDR = 1'b0;
    localparam logic REG_SEND_STOP  = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_ADDRESS  = 3'd1,
        PH_TRANSMIT = 3'd2,
        PH_RECEIVE  = 3'd3,
        PH_ERROR    = 3'd4
    } t_phase;

    typedef enum logic [3:0] {
        K_NOP,
        K_START_RD,
        K_START_WR,
        K_ST_START,
        K_AW_ACK,
        K_AR_ACK,
        K_TX_DONE,
        K_RX_ACK,
        K_RX_NACK,
        K_FAIL,
        K_ST_OTHER
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] length;
        logic [7:0]  line_data;
        logic [7:0]  tx_byte;
    } t_qitem;

    typedef struct packed {
        logic        load_data;
        logic [7:0]  data_value;
        logic        tx_taken;
        logic        set_start;
        logic        set_stop;
        logic        clear_start;
        logic [1:0]  ack_control;
        logic        clear_interrupt;
        logic        rx_valid;
        logic [7:0]  rx_value;
        logic        done_event;
        t_phase      phase;
    } t_result;

endpackage

>>> rtl/core/i2cmts_front.sv
// Front end: decodes an input item into an action kind for the queue.
// Depends on i2cmts_pkg.
module i2cmts_front (
    input  logic [1:0]       i_opcode,
    input  logic [15:0]      i_length,
    input  logic [7:0]       i_status_code,
    input  logic [7:0]       i_line_data,
    input  logic [7:0]       i_next_tx_byte,
    output i2cmts_pkg::t_qitem o_item
);

    i2cmts_pkg::t_kind w_status_kind;

    always_comb begin
        case (i_status_code)
            i2cmts_pkg::ST_START,
            i2cmts_pkg::ST_RESTART:  w_status_kind = i2cmts_pkg::K_ST_START;
            i2cmts_pkg::ST_AW_ACK:   w_status_kind = i2cmts_pkg::K_AW_ACK;
            i2cmts_pkg::ST_AR_ACK:   w_status_kind = i2cmts_pkg::K_AR_ACK;
            i2cmts_pkg::ST_TX_ACK,
            i2cmts_pkg::ST_TX_NACK:  w_status_kind = i2cmts_pkg::K_TX_DONE;
            i2cmts_pkg::ST_RX_ACK:   w_status_kind = i2cmts_pkg::K_RX_ACK;
            i2cmts_pkg::ST_RX_NACK:  w_status_kind = i2cmts_pkg::K_RX_NACK;
            i2cmts_pkg::ST_ARB_LOST,
            i2cmts_pkg::ST_AW_NACK,
            i2cmts_pkg::ST_AR_NACK:  w_status_kind = i2cmts_pkg::K_FAIL;
            default:                 w_status_kind = i2cmts_pkg::K_ST_OTHER;
        endcase
    end

    always_comb begin
        o_item.length    = i_length;
        o_item.line_data = i_line_data;
        o_item.tx_byte   = i_next_tx_byte;
        case (i_opcode)
            i2cmts_pkg::OP_START_RD: begin
                o_item.kind = (i_length != 16'd0) ? i2cmts_pkg::K_START_RD : i2cmts_pkg::K_NOP;
            end
            i2cmts_pkg::OP_START_WR: begin
                o_item.kind = (i_length != 16'd0) ? i2cmts_pkg::K_START_WR : i2cmts_pkg::K_NOP;
            end
            i2cmts_pkg::OP_STATUS: begin
                o_item.kind = w_status_kind;
            end
            default: begin
                o_item.kind = i2cmts_pkg::K_NOP;
            end
        endcase
    end

endmodule

>>> rtl/core/i2cmts_queue.sv
// Short FIFO of decoded items between front end and back end.
// Depends on i2cmts_pkg.
module i2cmts_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  i2cmts_pkg::t_qitem i_item,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_valid,
    output i2cmts_pkg::t_qitem o_item
);

    i2cmts_pkg::t_qitem             r_mem [i2cmts_pkg::QDEPTH];
    logic [i2cmts_pkg::QPTR_W-1:0]  r_wptr;
    logic [i2cmts_pkg::QPTR_W-1:0]  r_rptr;
    logic [i2cmts_pkg::QPTR_W:0]    r_count;

    logic w_push;
    logic w_pop;

    assign o_full  = (r_count == (i2cmts_pkg::QPTR_W+1)'(i2cmts_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + (i2cmts_pkg::QPTR_W)'(1);
            end
            if (w_pop) begin
                r_rptr <= r_rptr + (i2cmts_pkg::QPTR_W)'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + (i2cmts_pkg::QPTR_W+1)'(1);
                2'b01:   r_count <= r_count - (i2cmts_pkg::QPTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/core/i2cmts_back.sv
// Back end: executes decoded items against the transfer state and
// registers one result per item. Depends on i2cmts_pkg.
module i2cmts_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_item_valid,
    input  i2cmts_pkg::t_qitem  i_item,
    output logic                o_item_pop,
    input  logic [6:0]          i_slave_address,
    input  logic                i_send_stop,
    output logic                o_res_valid,
    output i2cmts_pkg::t_result o_res,
    input  logic                i_res_ready
);

    i2cmts_pkg::t_phase  r_phase;
    i2cmts_pkg::t_phase  n_phase;
    logic [15:0]         r_tx_rem;
    logic [15:0]         n_tx_rem;
    logic [15:0]         r_rx_rem;
    logic [15:0]         n_rx_rem;
    logic                r_out_valid;
    i2cmts_pkg::t_result r_out;
    i2cmts_pkg::t_result n_out;

    logic [15:0] w_tx_dec;
    logic [15:0] w_rx_dec;

    assign o_item_pop  = i_item_valid && (!r_out_valid || i_res_ready);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;
    assign w_tx_dec    = (r_tx_rem == 16'd0) ? 16'd0 : r_tx_rem - 16'd1;
    assign w_rx_dec    = (r_rx_rem == 16'd0) ? 16'd0 : r_rx_rem - 16'd1;

    always_comb begin
        n_phase  = r_phase;
        n_tx_rem = r_tx_rem;
        n_rx_rem = r_rx_rem;
        n_out    = '0;
        case (i_item.kind)
            i2cmts_pkg::K_START_RD: begin
                n_rx_rem              = i_item.length;
                n_tx_rem              = 16'd0;
                n_out.clear_interrupt = !i_send_stop;
                n_out.set_start       = 1'b1;
                n_phase               = i2cmts_pkg::PH_ADDRESS;
            end
            i2cmts_pkg::K_START_WR: begin
                n_rx_rem        = 16'd0;
                n_tx_rem        = i_item.length;
                n_out.set_start = 1'b1;
                n_phase         = i2cmts_pkg::PH_ADDRESS;
            end
            i2cmts_pkg::K_ST_START: begin
                n_out.clear_interrupt = 1'b1;
                n_out.clear_start     = 1'b1;
                if (r_phase == i2cmts_pkg::PH_ADDRESS) begin
                    n_out.load_data  = 1'b1;
                    n_out.data_value = {i_slave_address, (r_tx_rem == 16'd0)};
                end
            end
            i2cmts_pkg::K_AW_ACK: begin
                n_out.clear_interrupt = 1'b1;
                n_tx_rem              = w_tx_dec;
                n_out.load_data       = 1'b1;
                n_out.data_value      = i_item.tx_byte;
                n_out.tx_taken        = 1'b1;
                n_phase               = i2cmts_pkg::PH_TRANSMIT;
            end
            i2cmts_pkg::K_AR_ACK: begin
                n_out.clear_interrupt = 1'b1;
                n_out.ack_control     = (r_rx_rem > 16'd1) ? i2cmts_pkg::ACK_ACK
                                                           : i2cmts_pkg::ACK_NACK;
                n_phase               = i2cmts_pkg::PH_RECEIVE;
            end
            i2cmts_pkg::K_TX_DONE: begin
                n_out.clear_interrupt = 1'b1;
                if (r_phase == i2cmts_pkg::PH_TRANSMIT) begin
                    if (r_tx_rem != 16'd0) begin
                        n_out.load_data  = 1'b1;
                        n_out.data_value = i_item.tx_byte;
                        n_out.tx_taken   = 1'b1;
                        n_tx_rem         = w_tx_dec;
                    end else begin
                        n_out.set_stop   = i_send_stop;
                        n_out.done_event = 1'b1;
                        n_phase          = i2cmts_pkg::PH_IDLE;
                    end
                end
            end
            i2cmts_pkg::K_RX_ACK: begin
                n_out.clear_interrupt = 1'b1;
                n_rx_rem              = w_rx_dec;
                n_out.rx_valid        = 1'b1;
                n_out.rx_value        = i_item.line_data;
                n_out.ack_control     = (w_rx_dec > 16'd1) ? i2cmts_pkg::ACK_ACK
                                                           : i2cmts_pkg::ACK_NACK;
            end
            i2cmts_pkg::K_RX_NACK: begin
                n_out.clear_interrupt = 1'b1;
                if (r_phase == i2cmts_pkg::PH_RECEIVE) begin
                    n_rx_rem         = w_rx_dec;
                    n_out.rx_valid   = 1'b1;
                    n_out.rx_value   = i_item.line_data;
                    n_out.set_stop   = 1'b1;
                    n_out.done_event = 1'b1;
                    n_phase          = i2cmts_pkg::PH_IDLE;
                end
            end
            i2cmts_pkg::K_FAIL: begin
                n_out.clear_interrupt = 1'b1;
                n_out.set_stop        = 1'b1;
                n_out.done_event      = 1'b1;
                n_phase               = i2cmts_pkg::PH_ERROR;
            end
            i2cmts_pkg::K_ST_OTHER: begin
                n_out.clear_interrupt = 1'b1;
            end
            default: begin
                n_out = '0;
            end
        endcase
        n_out.phase = n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= i2cmts_pkg::PH_IDLE;
            r_tx_rem    <= '0;
            r_rx_rem    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_item_pop) begin
                r_phase     <= n_phase;
                r_tx_rem    <= n_tx_rem;
                r_rx_rem    <= n_rx_rem;
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_item_pop) begin
            r_out <= n_out;
        end
    end

    a_done_ends_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.done_event |->
            (r_out.phase == i2cmts_pkg::PH_IDLE || r_out.phase == i2cmts_pkg::PH_ERROR))
        else $error("done without idle or error phase");

    a_fail_to_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_item_pop && i_item.kind == i2cmts_pkg::K_FAIL |=>
            r_phase == i2cmts_pkg::PH_ERROR && r_out.set_stop)
        else $error("failure status did not reach error phase");

    a_tx_taken_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.tx_taken |-> r_out.load_data && !r_out.rx_valid)
        else $error("tx byte taken without data write");

    a_phase_tracks_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.phase == r_phase)
        else $error("reported phase differs from state");

endmodule

>>> rtl/core/i2c_master_transfer_sequencer.sv
// I2C master transfer sequencer.
// Input item stream on s_t*, result stream on m_t*, APB register port.
// Front end decodes opcode and status code, a 4-entry queue decouples it
// from the back end, which holds the transfer state and an output register.
// Every accepted item yields exactly one result item, in order.
// Each accepted item is written into the queue; the back end then registers its result in the output register.
// Throughput: one item per cycle while m_tready is high; a stalled result holds the back end.
// Registers: slave_address at 0x0 (7 bits, reset 0), send_stop at 0x4
// (1 bit, reset 1). Write them only while no item is in flight.
// Reset clears phase to idle, both byte counters and the queue.
// When m_tready is low the output register holds its result, the queue
// fills up to 4 items and then s_tready drops until results are taken.
// Depends on i2cmts_pkg, i2cmts_front, i2cmts_queue, i2cmts_back.
module i2c_master_transfer_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // length[15:0], status_code[23:16], line_data[31:24], next_tx_byte[39:32]
    input  logic [39:0] s_tdata,
    // opcode[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // load_data[0], data_value[8:1], tx_taken[9], set_start[10], set_stop[11],
    // clear_start[12], ack_control[14:13], clear_interrupt[15], rx_valid[16],
    // rx_value[24:17], done_event[25], phase[28:26], zero[31:29]
    output logic [31:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [6:0] r_slave_address;
    logic       r_send_stop;
    logic       w_cfg_wr;
    logic       w_q_full;
    logic       w_q_valid;
    logic       w_q_pop;

    i2cmts_pkg::t_qitem  w_front_item;
    i2cmts_pkg::t_qitem  w_q_item;
    i2cmts_pkg::t_result w_res;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == i2cmts_pkg::REG_SEND_STOP) ? {31'd0, r_send_stop}
                                                              : {25'd0, r_slave_address};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_address <= 7'd0;
            r_send_stop     <= 1'b1;
        end else if (w_cfg_wr) begin
            if (paddr[2] == i2cmts_pkg::REG_SLAVE_ADDR) begin
                r_slave_address <= pwdata[6:0];
            end else begin
                r_send_stop <= pwdata[0];
            end
        end
    end

    assign s_tready = !w_q_full;

    i2cmts_front u_front (
        .i_opcode       (s_tuser),
        .i_length       (s_tdata[15:0]),
        .i_status_code  (s_tdata[23:16]),
        .i_line_data    (s_tdata[31:24]),
        .i_next_tx_byte (s_tdata[39:32]),
        .o_item         (w_front_item)
    );

    i2cmts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_tvalid),
        .i_item  (w_front_item),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    i2cmts_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item_valid    (w_q_valid),
        .i_item          (w_q_item),
        .o_item_pop      (w_q_pop),
        .i_slave_address (r_slave_address),
        .i_send_stop     (r_send_stop),
        .o_res_valid     (m_tvalid),
        .o_res           (w_res),
        .i_res_ready     (m_tready)
    );

    assign m_tdata = {3'd0,
                      w_res.phase,
                      w_res.done_event,
                      w_res.rx_value,
                      w_res.rx_valid,
                      w_res.clear_interrupt,
                      w_res.ack_control,
                      w_res.clear_start,
                      w_res.set_stop,
                      w_res.set_start,
                      w_res.tx_taken,
                      w_res.data_value,
                      w_res.load_data};

endmodule

>>> bench/i2c_master_transfer_sequencer_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for i2c_master_transfer_sequencer: directed table, then random transfers.
// Each accepted item runs through a local transfer-sequencer model; results are checked in order.
// Depends on i2cmts_pkg and the i2c_master_transfer_sequencer RTL only.
module i2c_master_transfer_sequencer_tb;

    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam logic [7:0] ST_UNKNOWN_LO = 8'h00;
    localparam logic [7:0] ST_UNKNOWN_HI = 8'hFF;
    localparam int ITEMS_PER_SETTING     = 350;
    localparam int NUM_SETTINGS          = 5;
    localparam int HOLDOFF_CYCLES        = 400;
    localparam int CYCLE_LIMIT           = 400000;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] length;
        logic [7:0]  status;
        logic [7:0]  line;
        logic [7:0]  txb;
    } t_bus_event;

    typedef struct {
        t_bus_event          ev;
        bit                  typed;
        i2cmts_pkg::t_result want;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    i2c_master_transfer_sequencer uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // model state
    logic [6:0]         cfg_addr = '0;
    logic               cfg_stop = 1'b1;
    i2cmts_pkg::t_phase model_phase = i2cmts_pkg::PH_IDLE;
    logic [15:0]        tx_left = '0;
    logic [15:0]        rx_left = '0;

    i2cmts_pkg::t_result expected_actions [$];
    logic [7:0] status_codes [11] = '{i2cmts_pkg::ST_START, i2cmts_pkg::ST_RESTART,
        i2cmts_pkg::ST_AW_ACK, i2cmts_pkg::ST_AW_NACK, i2cmts_pkg::ST_TX_ACK,
        i2cmts_pkg::ST_TX_NACK, i2cmts_pkg::ST_ARB_LOST, i2cmts_pkg::ST_AR_ACK,
        i2cmts_pkg::ST_AR_NACK, i2cmts_pkg::ST_RX_ACK, i2cmts_pkg::ST_RX_NACK};

    int  mismatches = 0;
    int  results_checked = 0;
    int  live_items = 0;
    int  ignored_items = 0;
    int  transfers_closed = 0;
    int  settings_applied = 0;
    int  cycle_count = 0;
    int  holdoff_requests = 0;
    int  holdoffs_served = 0;
    int  hold_left = 0;
    bit  steady = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic i2cmts_pkg::t_result sequencer_step(t_bus_event ev);
        i2cmts_pkg::t_result r;
        r = '0;
        if (ev.op == i2cmts_pkg::OP_START_RD || ev.op == i2cmts_pkg::OP_START_WR) begin
            if (ev.length != 16'd0) begin
                if (ev.op == i2cmts_pkg::OP_START_RD) begin
                    rx_left = ev.length;
                    tx_left = '0;
                    if (!cfg_stop) r.clear_interrupt = 1'b1;
                end else begin
                    rx_left = '0;
                    tx_left = ev.length;
                end
                model_phase = i2cmts_pkg::PH_ADDRESS;
                r.set_start = 1'b1;
            end
        end else if (ev.op == i2cmts_pkg::OP_STATUS) begin
            r.clear_interrupt = 1'b1;
            case (ev.status)
                i2cmts_pkg::ST_START, i2cmts_pkg::ST_RESTART: begin
                    if (model_phase == i2cmts_pkg::PH_ADDRESS) begin
                        r.load_data = 1'b1;
                        r.data_value = {cfg_addr, tx_left == 16'd0};
                    end
                    r.clear_start = 1'b1;
                end
                i2cmts_pkg::ST_AW_ACK: begin
                    if (tx_left != 16'd0) tx_left = tx_left - 16'd1;
                    r.load_data = 1'b1;
                    r.data_value = ev.txb;
                    r.tx_taken = 1'b1;
                    model_phase = i2cmts_pkg::PH_TRANSMIT;
                end
                i2cmts_pkg::ST_AR_ACK: begin
                    r.ack_control = (rx_left > 16'd1) ? i2cmts_pkg::ACK_ACK
                                                      : i2cmts_pkg::ACK_NACK;
                    model_phase = i2cmts_pkg::PH_RECEIVE;
                end
                i2cmts_pkg::ST_TX_ACK, i2cmts_pkg::ST_TX_NACK: begin
                    if (model_phase == i2cmts_pkg::PH_TRANSMIT) begin
                        if (tx_left != 16'd0) begin
                            r.load_data = 1'b1;
                            r.data_value = ev.txb;
                            r.tx_taken = 1'b1;
                            tx_left = tx_left - 16'd1;
                        end else begin
                            r.set_stop = cfg_stop;
                            model_phase = i2cmts_pkg::PH_IDLE;
                            r.done_event = 1'b1;
                        end
                    end
                end
                i2cmts_pkg::ST_RX_ACK: begin
                    if (rx_left != 16'd0) rx_left = rx_left - 16'd1;
                    r.rx_valid = 1'b1;
                    r.rx_value = ev.line;
                    r.ack_control = (rx_left > 16'd1) ? i2cmts_pkg::ACK_ACK
                                                      : i2cmts_pkg::ACK_NACK;
                end
                i2cmts_pkg::ST_RX_NACK: begin
                    if (model_phase == i2cmts_pkg::PH_RECEIVE) begin
                        if (rx_left != 16'd0) rx_left = rx_left - 16'd1;
                        r.rx_valid = 1'b1;
                        r.rx_value = ev.line;
                        r.set_stop = 1'b1;
                        model_phase = i2cmts_pkg::PH_IDLE;
                        r.done_event = 1'b1;
                    end
                end
                i2cmts_pkg::ST_ARB_LOST, i2cmts_pkg::ST_AW_NACK, i2cmts_pkg::ST_AR_NACK: begin
                    r.set_stop = 1'b1;
                    model_phase = i2cmts_pkg::PH_ERROR;
                    r.done_event = 1'b1;
                end
                default: begin
                end
            endcase
        end
        r.phase = model_phase;
        return r;
    endfunction

    function automatic i2cmts_pkg::t_result typed_result(logic dw, logic [7:0] dv, logic ss,
                                                         logic sp, logic cs, logic [1:0] ak,
                                                         logic ci, logic dn,
                                                         i2cmts_pkg::t_phase ph);
        i2cmts_pkg::t_result r;
        r = '0;
        r.load_data = dw;
        r.data_value = dv;
        r.set_start = ss;
        r.set_stop = sp;
        r.clear_start = cs;
        r.ack_control = ak;
        r.clear_interrupt = ci;
        r.done_event = dn;
        r.phase = ph;
        return r;
    endfunction

    function automatic t_bus_event random_event();
        t_bus_event ev;
        ev.op = 2'($urandom_range(3));
        ev.length = 16'($urandom_range(65535));
        ev.status = $urandom_range(1) ? status_codes[$urandom_range(10)]
                                      : 8'($urandom_range(255));
        ev.line = 8'($urandom_range(255));
        ev.txb = 8'($urandom_range(255));
        return ev;
    endfunction

    task automatic offer(t_bus_event ev, bit typed = 1'b0, i2cmts_pkg::t_result want = '0);
        i2cmts_pkg::t_result nxt;
        if (!steady) begin
            while ($urandom_range(99) < 35) begin
                s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= {ev.txb, ev.line, ev.status, ev.length};
        s_tuser <= ev.op;
        do @(posedge i_clk); while (!s_tready);
        nxt = sequencer_step(ev);
        expected_actions.push_back(typed ? want : nxt);
        if (nxt.done_event) transfers_closed++;
        if (ev.op == OP_UNUSED || (ev.op != i2cmts_pkg::OP_STATUS && ev.length == 16'd0))
            ignored_items++;
        else live_items++;
    endtask

    task automatic maybe_noise();
        if ($urandom_range(99) < 6) offer(random_event());
    endtask

    // mostly well-formed transfers with random payload, aborts and stray items mixed in
    task automatic random_transfer();
        t_bus_event ev;
        int n;
        int steps;
        bit rd;
        rd = 1'($urandom_range(1));
        n = ($urandom_range(24) == 0) ? $urandom_range(65535) : $urandom_range(1, 6);
        ev = random_event();
        ev.op = rd ? i2cmts_pkg::OP_START_RD : i2cmts_pkg::OP_START_WR;
        ev.length = 16'(n);
        offer(ev);
        maybe_noise();
        ev = random_event();
        ev.op = i2cmts_pkg::OP_STATUS;
        ev.status = $urandom_range(1) ? i2cmts_pkg::ST_START : i2cmts_pkg::ST_RESTART;
        offer(ev);
        maybe_noise();
        ev = random_event();
        ev.op = i2cmts_pkg::OP_STATUS;
        if ($urandom_range(19) == 0) begin
            ev.status = $urandom_range(1) ? i2cmts_pkg::ST_ARB_LOST
                      : (rd ? i2cmts_pkg::ST_AR_NACK : i2cmts_pkg::ST_AW_NACK);
            offer(ev);
            return;
        end
        ev.status = rd ? i2cmts_pkg::ST_AR_ACK : i2cmts_pkg::ST_AW_ACK;
        offer(ev);
        steps = (n > 8) ? 8 : n;
        for (int i = 0; i < steps; i++) begin
            maybe_noise();
            ev = random_event();
            ev.op = i2cmts_pkg::OP_STATUS;
            if (rd) ev.status = (i == steps - 1) ? i2cmts_pkg::ST_RX_NACK
                                                 : i2cmts_pkg::ST_RX_ACK;
            else ev.status = $urandom_range(1) ? i2cmts_pkg::ST_TX_ACK
                                               : i2cmts_pkg::ST_TX_NACK;
            if ($urandom_range(29) == 0) ev.status = i2cmts_pkg::ST_ARB_LOST;
            offer(ev);
        end
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_register(logic idx, logic [31:0] value);
        logic [31:0] rdata;
        logic [31:0] want;
        apb_access(1'b1, {idx, 2'b00}, value, rdata);
        if (idx == i2cmts_pkg::REG_SLAVE_ADDR) cfg_addr = value[6:0];
        else cfg_stop = value[0];
        want = (idx == i2cmts_pkg::REG_SLAVE_ADDR) ? {25'd0, cfg_addr} : {31'd0, cfg_stop};
        apb_access(1'b0, {idx, 2'b00}, '0, rdata);
        if (rdata !== want) begin
            if (mismatches < 10)
                $display("register %0d readback: expected %h, got %h", idx, want, rdata);
            mismatches++;
        end
    endtask

    task automatic drain();
        while (expected_actions.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // result sink: random stalls, a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holdoff_requests != holdoffs_served) begin
            m_tready <= 1'b0;
            hold_left <= HOLDOFF_CYCLES;
            holdoffs_served <= holdoffs_served + 1;
        end else if (steady) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= 35);
        end
    end

    always @(posedge i_clk) begin
        i2cmts_pkg::t_result got;
        i2cmts_pkg::t_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.load_data = m_tdata[0];
            got.data_value = m_tdata[8:1];
            got.tx_taken = m_tdata[9];
            got.set_start = m_tdata[10];
            got.set_stop = m_tdata[11];
            got.clear_start = m_tdata[12];
            got.ack_control = m_tdata[14:13];
            got.clear_interrupt = m_tdata[15];
            got.rx_valid = m_tdata[16];
            got.rx_value = m_tdata[24:17];
            got.done_event = m_tdata[25];
            got.phase = i2cmts_pkg::t_phase'(m_tdata[28:26]);
            if (expected_actions.size() == 0) begin
                if (mismatches < 10) $display("result with nothing expected: %p", got);
                mismatches++;
            end else begin
                want = expected_actions.pop_front();
                results_checked++;
                if (got !== want) begin
                    if (mismatches < 10)
                        $display("result %0d: expected %p, got %p", results_checked, want, got);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("i2c_master_transfer_sequencer_tb NOT OK");
            $finish;
        end
    end

    initial begin
        t_stim_row  directed [$];
        logic [6:0] addr_sel [NUM_SETTINGS];
        logic       stop_sel [NUM_SETTINGS];
        int         base;

        directed = '{
            '{'{i2cmts_pkg::OP_STATUS, 16'h0000, i2cmts_pkg::ST_START, 8'h00, 8'h00}, 1'b1,
              typed_result(1'b0, 8'h00, 1'b0, 1'b0, 1'b1, i2cmts_pkg::ACK_NONE, 1'b1, 1'b0,
                           i2cmts_pkg::PH_IDLE)},
            '{'{OP_UNUSED, 16'hFFFF, ST_UNKNOWN_HI, 8'hFF, 8'hFF}, 1'b1,
              typed_result(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, i2cmts_pkg::ACK_NONE, 1'b0, 1'b0,
                           i2cmts_pkg::PH_IDLE)},
            '{'{i2cmts_pkg::OP_START_WR, 16'h0000, ST_UNKNOWN_HI, 8'hFF, 8'hFF}, 1'b1,
              typed_result(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, i2cmts_pkg::ACK_NONE, 1'b0, 1'b0,
                           i2cmts_pkg::PH_IDLE)},
            '{'{i2cmts_pkg::OP_START_RD, 16'hFFFF, ST_UNKNOWN_LO, 8'h00, 8'h00}, 1'b1,
              typed_result(1'b0, 8'h00, 1'b1, 1'b0, 1'b0, i2cmts_pkg::ACK_NONE, 1'b0, 1'b0,
                           i2cmts_pkg::PH_ADDRESS)},
            '{'{i2cmts_pkg::OP_STATUS, 16'hFFFF, i2cmts_pkg::ST_RESTART, 8'hFF, 8'hFF}, 1'b1,
              typed_result(1'b1, 8'h01, 1'b0, 1'b0, 1'b1, i2cmts_pkg::ACK_NONE, 1'b1, 1'b0,
                           i2cmts_pkg::PH_ADDRESS)},
            '{'{i2cmts_pkg::OP_STATUS, 16'h0000, i2cmts_pkg::ST_AR_ACK, 8'h00, 8'h00}, 1'b1,
              typed_result(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, i2cmts_pkg::ACK_ACK, 1'b1, 1'b0,
                           i2cmts_pkg::PH_RECEIVE)},
            '{'{i2cmts_pkg::OP_STATUS, 16'h0000, i2cmts_pkg::ST_RX_ACK, 8'hFF, 8'h00}, 1'b0, '0},
            '{'{i2cmts_pkg::OP_STATUS, 16'h0000, i2cmts_pkg::ST_RX_NACK, 8'h00, 8'hFF}, 1'b0, '0},
            '{'{i2cmts_pkg::OP_STATUS, 16'h0000, i2cmts_pkg::ST_RX_NACK, 8'hA5, 8'h00}, 1'b0, '0},
            '{'{i2cmts_pkg::OP_START_WR, 16'h0001, ST_UNKNOWN_LO, 8'h00, 8'h00}, 1'b0, '0},
            '{'{i2cmts_pkg::OP_STATUS, 16'h0000, i2cmts_pkg::ST_START, 8'h00, 8'h00}, 1'b0, '0},
            '{'{i2cmts_pkg::OP_STATUS, 16'h0000, i2cmts_pkg::ST_AW_ACK, 8'h00, 8'hFF}, 1'b0, '0},
            '{'{i2cmts_pkg::OP_STATUS, 16'h0000, i2cmts_pkg::ST_TX_ACK, 8'h00, 8'h3C}, 1'b0, '0},
            '{'{i2cmts_pkg::OP_STATUS, 16'h0000, i2cmts_pkg::ST_TX_NACK, 8'h00, 8'h3C}, 1'b0, '0},
            '{'{i2cmts_pkg::OP_START_WR, 16'h0003, ST_UNKNOWN_LO, 8'h00, 8'h00}, 1'b0, '0},
            '{'{i2cmts_pkg::OP_STATUS, 16'h0000, i2cmts_pkg::ST_AW_NACK, 8'h00, 8'h00}, 1'b1,
              typed_result(1'b0, 8'h00, 1'b0, 1'b1, 1'b0, i2cmts_pkg::ACK_NONE, 1'b1, 1'b1,
                           i2cmts_pkg::PH_ERROR)},
            '{'{i2cmts_pkg::OP_STATUS, 16'h0000, i2cmts_pkg::ST_AR_NACK, 8'h00, 8'h00}, 1'b1,
              typed_result(1'b0, 8'h00, 1'b0, 1'b1, 1'b0, i2cmts_pkg::ACK_NONE, 1'b1, 1'b1,
                           i2cmts_pkg::PH_ERROR)},
            '{'{i2cmts_pkg::OP_STATUS, 16'h0000, i2cmts_pkg::ST_ARB_LOST, 8'h00, 8'h00}, 1'b1,
              typed_result(1'b0, 8'h00, 1'b0, 1'b1, 1'b0, i2cmts_pkg::ACK_NONE, 1'b1, 1'b1,
                           i2cmts_pkg::PH_ERROR)},
            '{'{i2cmts_pkg::OP_STATUS, 16'h0000, ST_UNKNOWN_HI, 8'hFF, 8'hFF}, 1'b1,
              typed_result(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, i2cmts_pkg::ACK_NONE, 1'b1, 1'b0,
                           i2cmts_pkg::PH_ERROR)},
            '{'{i2cmts_pkg::OP_STATUS, 16'hFFFF, ST_UNKNOWN_LO, 8'h00, 8'h00}, 1'b1,
              typed_result(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, i2cmts_pkg::ACK_NONE, 1'b1, 1'b0,
                           i2cmts_pkg::PH_ERROR)},
            '{'{i2cmts_pkg::OP_STATUS, 16'h0000, i2cmts_pkg::ST_AW_ACK, 8'h00, 8'h00}, 1'b0, '0},
            '{'{i2cmts_pkg::OP_STATUS, 16'h0000, i2cmts_pkg::ST_TX_NACK, 8'h00, 8'h5A}, 1'b0, '0},
            '{'{i2cmts_pkg::OP_START_RD, 16'h0001, ST_UNKNOWN_LO, 8'h00, 8'h00}, 1'b0, '0},
            '{'{i2cmts_pkg::OP_STATUS, 16'h0000, i2cmts_pkg::ST_AR_ACK, 8'h00, 8'h00}, 1'b0, '0},
            '{'{i2cmts_pkg::OP_STATUS, 16'h0000, i2cmts_pkg::ST_RX_ACK, 8'h81, 8'h00}, 1'b0, '0},
            '{'{i2cmts_pkg::OP_STATUS, 16'h0000, i2cmts_pkg::ST_RX_ACK, 8'h7E, 8'h00}, 1'b0, '0}
        };
        addr_sel = '{7'h7F, 7'h2A, 7'h55, 7'($urandom_range(127)), 7'h00};
        stop_sel = '{1'b0, 1'b1, 1'b0, 1'($urandom_range(1)), 1'b1};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) offer(directed[i].ev, directed[i].typed, directed[i].want);
        s_tvalid <= 1'b0;

        for (int p = 0; p < NUM_SETTINGS; p++) begin
            drain();
            set_register(i2cmts_pkg::REG_SLAVE_ADDR, {25'd0, addr_sel[p]});
            set_register(i2cmts_pkg::REG_SEND_STOP, {31'd0, stop_sel[p]});
            settings_applied++;
            steady <= (p == 1);
            if (p == 2) holdoff_requests <= holdoff_requests + 1;
            base = live_items;
            while (live_items - base < ITEMS_PER_SETTING) random_transfer();
            s_tvalid <= 1'b0;
        end
        steady <= 1'b0;

        drain();
        repeat (8) @(posedge i_clk);

        $display("run: %0d items (%0d ignored), %0d results checked, %0d transfers closed,",
                 live_items + ignored_items, ignored_items, results_checked, transfers_closed);
        $display("     %0d register settings, %0d mismatches", settings_applied, mismatches);
        if (mismatches == 0 && expected_actions.size() == 0) begin
            $display("i2c_master_transfer_sequencer_tb OK");
        end else begin
            $display("i2c_master_transfer_sequencer_tb NOT OK");
        end
        $finish;
    end

endmodule
